@@ sv/gstw_pkg.sv @@
// gstw_pkg: shared constants, types and helpers for the grid segment tile walker
// used by gstw_div and grid_segment_tile_walk; depends on nothing else
`default_nettype none

package gstw_pkg;

  // coordinate format, unsigned fixed point
  localparam int COORD_INT_BITS  = 12;
  localparam int COORD_FRAC_BITS = 12;
  localparam int COORD_W         = COORD_INT_BITS + COORD_FRAC_BITS;

  // gradient and walk limits
  localparam int GRAD_FRAC = 16;
  localparam int MAX_SPAN  = 31;
  localparam int SPAN_W    = $clog2(MAX_SPAN + 1);

  // major delta width for a walkable segment, gradient quotient and signed gradient
  localparam int DMAJ_W = SPAN_W + COORD_FRAC_BITS;
  localparam int Q_W    = GRAD_FRAC + 1;
  localparam int G_W    = Q_W + 1;
  localparam int CNT_W  = $clog2(Q_W);

  // intercept: signed, COORD_FRAC_BITS + GRAD_FRAC fraction bits, two guard bits
  localparam int ROW_SH = COORD_FRAC_BITS + GRAD_FRAC;
  localparam int ICPT_W = COORD_W + GRAD_FRAC + 2;
  localparam int ROW_W  = ICPT_W - ROW_SH;
  localparam int PROD_W = G_W + COORD_FRAC_BITS + 1;

  // result cell and stream widths
  localparam int CELL_W = 12;
  localparam int IN_W   = ((4 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * CELL_W + 7) / 8) * 8;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWAP,
    ST_ORDER,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_INIT,
    ST_FIRST,
    ST_ADV,
    ST_COL,
    ST_EXTRA,
    ST_OVF
  } state_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DMAJ_W-1:0] num;
    logic [DMAJ_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } div_rsp_t;

  // integer part of the intercept, truncated toward zero
  function automatic logic signed [ROW_W-1:0] row_of(input logic signed [ICPT_W-1:0] icpt);
    logic signed [ROW_W-1:0] ip;
    ip = icpt[ICPT_W-1:ROW_SH];
    if (icpt[ICPT_W-1] && (|icpt[ROW_SH-1:0])) begin
      ip = ip + ROW_W'(1);
    end
    return ip;
  endfunction

endpackage

`default_nettype wire

@@ sv/gstw_div.sv @@
// gstw_div: restoring divider, one quotient bit per cycle, for the segment gradient
// computes (num << GRAD_FRAC) / den with num <= den; uses gstw_pkg
`default_nettype none

module gstw_div
  import gstw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DMAJ_W-1:0]   rem_r;
  logic [DMAJ_W-1:0]   den_r;
  logic [GRAD_FRAC:0]  sh_r;
  logic [Q_W-1:0]      q_r;

  logic [DMAJ_W:0]     trial;
  logic [DMAJ_W:0]     diff;
  logic                ge;

  // one trial subtract per cycle
  assign trial = {rem_r, sh_r[GRAD_FRAC]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath: the top bits of the numerator seed the remainder since the quotient fits Q_W bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.num[DMAJ_W-1:1]};
      sh_r  <= {req.num[0], {GRAD_FRAC{1'b0}}};
      den_r <= req.den;
      cnt_r <= CNT_W'(Q_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DMAJ_W-1:0] : trial[DMAJ_W-1:0];
      sh_r  <= {sh_r[GRAD_FRAC-1:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

`default_nettype wire

@@ sv/grid_segment_tile_walk.sv @@
// grid_segment_tile_walk: lists the grid cells crossed by one segment per input beat
// before the first cell, the gradient is found by the 17-step divider
// each column walked takes an advance state and an emit state, plus an extra state on a row
// crossing; a new segment is accepted only after the last cell of the one before is registered
// a segment over the span limit gives a single flagged beat
// reset: synchronous active-low rst_n clears the sequencer, divider control and out_tvalid
`default_nettype none

module grid_segment_tile_walk
  import gstw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // tile_col, tile_row
  output logic                  out_tlast,
  output logic                  out_tuser   // span_overflow
);

  state_t state_r, state_nxt;

  logic [COORD_W-1:0]         sx_r, sy_r, ex_r, ey_r;
  logic                       steep_r;
  logic [COORD_W-1:0]         dmaj_r;
  logic signed [COORD_W:0]    dmin_r;
  logic signed [G_W-1:0]      g_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ICPT_W-1:0]   icpt_r;
  logic [COORD_INT_BITS-1:0]  x_r, xl_r;
  logic signed [ROW_W-1:0]    row_cur_r, row_new_r;

  logic                       out_tvalid_r;
  logic [OUT_W-1:0]           out_tdata_r;
  logic                       out_tlast_r;
  logic                       out_tuser_r;

  logic signed [COORD_W:0]    ddx, ddy, adx, ady;
  logic                       steep, rev;
  logic [COORD_INT_BITS-1:0]  span;
  logic [COORD_W:0]           dmin_mag;
  logic [COORD_FRAC_BITS-1:0] dfrac;
  logic signed [ROW_W-1:0]    row_now;
  logic                       can_load, at_end, extra;

  logic                       emit, e_last, e_ovf, x_inc;
  logic [CELL_W-1:0]          e_maj, e_min;
  logic                       div_start;

  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  // divider for the gradient
  gstw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // steepness, ordering and span helpers
  assign ddx      = $signed({1'b0, ex_r}) - $signed({1'b0, sx_r});
  assign ddy      = $signed({1'b0, ey_r}) - $signed({1'b0, sy_r});
  assign adx      = ddx[COORD_W] ? -ddx : ddx;
  assign ady      = ddy[COORD_W] ? -ddy : ddy;
  assign steep    = ady > adx;
  assign rev      = sx_r > ex_r;
  assign span     = ex_r[COORD_W-1:COORD_FRAC_BITS] - sx_r[COORD_W-1:COORD_FRAC_BITS];
  assign dmin_mag = dmin_r[COORD_W] ? COORD_W'(0) - dmin_r : dmin_r;
  assign dfrac    = COORD_FRAC_BITS'(0) - sx_r[COORD_FRAC_BITS-1:0];
  assign row_now  = row_of(icpt_r);
  assign can_load = !out_tvalid_r || out_tready;
  assign at_end   = x_r == xl_r;
  assign extra    = row_now != row_cur_r;

  assign div_req.start = div_start;
  assign div_req.num   = DMAJ_W'(dmin_mag);
  assign div_req.den   = DMAJ_W'(dmaj_r);

  assign in_tready = state_r == ST_IDLE;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: next state and result beats
  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    e_maj     = '0;
    e_min     = '0;
    e_last    = 1'b0;
    e_ovf     = 1'b0;
    x_inc     = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SWAP;
      end
      ST_SWAP:  state_nxt = ST_ORDER;
      ST_ORDER: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (span > COORD_INT_BITS'(MAX_SPAN)) begin
          state_nxt = ST_OVF;
        end else if (dmaj_r == '0) begin
          state_nxt = ST_MUL;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_FIRST;
      ST_FIRST: begin
        emit   = 1'b1;
        e_maj  = CELL_W'(x_r);
        e_min  = CELL_W'(sy_r[COORD_W-1:COORD_FRAC_BITS]);
        e_last = at_end;
        if (can_load) begin
          state_nxt = at_end ? ST_IDLE : ST_ADV;
          x_inc     = !at_end;
        end
      end
      ST_ADV: state_nxt = ST_COL;
      ST_COL: begin
        emit   = 1'b1;
        e_maj  = CELL_W'(x_r);
        e_min  = CELL_W'(row_cur_r);
        e_last = at_end && !extra;
        if (can_load) begin
          if (extra) begin
            state_nxt = ST_EXTRA;
          end else begin
            state_nxt = at_end ? ST_IDLE : ST_ADV;
            x_inc     = !at_end;
          end
        end
      end
      ST_EXTRA: begin
        emit   = 1'b1;
        e_maj  = CELL_W'(x_r);
        e_min  = CELL_W'(row_new_r);
        e_last = at_end;
        if (can_load) begin
          state_nxt = at_end ? ST_IDLE : ST_ADV;
          x_inc     = !at_end;
        end
      end
      ST_OVF: begin
        emit   = 1'b1;
        e_last = 1'b1;
        e_ovf  = 1'b1;
        if (can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // segment datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sx_r <= in_tdata[COORD_W-1:0];
          sy_r <= in_tdata[2*COORD_W-1:COORD_W];
          ex_r <= in_tdata[3*COORD_W-1:2*COORD_W];
          ey_r <= in_tdata[4*COORD_W-1:3*COORD_W];
        end
      end
      // make x the major axis
      ST_SWAP: begin
        steep_r <= steep;
        if (steep) begin
          sx_r <= sy_r;
          sy_r <= sx_r;
          ex_r <= ey_r;
          ey_r <= ex_r;
        end
      end
      // start gets the smaller major coordinate
      ST_ORDER: begin
        if (rev) begin
          sx_r   <= ex_r;
          sy_r   <= ey_r;
          ex_r   <= sx_r;
          ey_r   <= sy_r;
          dmaj_r <= sx_r - ex_r;
          dmin_r <= $signed({1'b0, sy_r}) - $signed({1'b0, ey_r});
        end else begin
          dmaj_r <= ex_r - sx_r;
          dmin_r <= $signed({1'b0, ey_r}) - $signed({1'b0, sy_r});
        end
      end
      ST_CHECK: begin
        x_r  <= sx_r[COORD_W-1:COORD_FRAC_BITS];
        xl_r <= ex_r[COORD_W-1:COORD_FRAC_BITS];
        g_r  <= G_W'(1) <<< GRAD_FRAC;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          g_r <= dmin_r[COORD_W] ? -$signed({1'b0, div_rsp.q}) : $signed({1'b0, div_rsp.q});
        end
      end
      // gradient times distance to the next column line
      ST_MUL: prod_r <= g_r * $signed({1'b0, dfrac});
      ST_INIT: begin
        icpt_r <= $signed({2'b00, sy_r, {GRAD_FRAC{1'b0}}})
                + $signed({{(ICPT_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
      end
      // advance the intercept by one column
      ST_ADV: begin
        row_cur_r <= row_now;
        icpt_r    <= icpt_r
                   + $signed({{(ICPT_W-G_W-COORD_FRAC_BITS){g_r[G_W-1]}}, g_r,
                              {COORD_FRAC_BITS{1'b0}}});
      end
      ST_COL: row_new_r <= row_now;
      default: ;
    endcase
    if (x_inc) begin
      x_r <= x_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit && can_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && can_load) begin
      out_tdata_r <= steep_r ? OUT_W'({e_maj, e_min}) : OUT_W'({e_min, e_maj});
      out_tlast_r <= e_last;
      out_tuser_r <= e_ovf;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  // checks
  a_ovf_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("overflow beat is not a lone zero cell");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_SWAP)
    else $error("accepted segment did not start processing");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COL || state_r == ST_EXTRA) |-> x_r <= xl_r)
    else $error("column walked past the segment end");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for grid_segment_tile_walk, one segment per input beat
// predicts the crossed cells per segment and checks every output beat; needs gstw_pkg and the RTL
module tb
  import gstw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_TILE = longint'(1) << COORD_FRAC_BITS;
  localparam int     COORD_MAX = (1 << COORD_W) - 1;
  localparam int     SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic              is_last;
    logic              ovf;
  } cell_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  logic              out_tuser;

  logic [IN_W-1:0]   seg_beats[$];
  cell_t             expected_cells[$];
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                mismatches = 0;
  int                n_segs = 0;
  int                n_cells = 0;
  int                n_ovf = 0;
  int                n_steep = 0;

  grid_segment_tile_walk i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // integer part of an intercept, truncated toward zero
  function automatic longint row_trunc(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >> (COORD_FRAC_BITS + GRAD_FRAC);
    return (v < 0) ? -m : m;
  endfunction

  function automatic cell_t make_cell(input longint major, input longint minor,
                                      input bit steep);
    cell_t c;
    c.col     = CELL_W'(steep ? minor : major);
    c.row     = CELL_W'(steep ? major : minor);
    c.is_last = 1'b0;
    c.ovf     = 1'b0;
    return c;
  endfunction

  // expected cells for one accepted segment
  function automatic void predict_cells(input logic [IN_W-1:0] beat);
    longint sx, sy, ex, ey, t, adx, ady, dmaj, dmin, grad, xceil, icpt, x, xlast, cur;
    bit     steep;
    cell_t  run[$];
    cell_t  c;
    sx = beat[COORD_W-1:0];
    sy = beat[2*COORD_W-1:COORD_W];
    ex = beat[3*COORD_W-1:2*COORD_W];
    ey = beat[4*COORD_W-1:3*COORD_W];
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    steep = ady > adx;
    n_segs++;
    if (steep) begin
      n_steep++;
      t = sx; sx = sy; sy = t;
      t = ex; ex = ey; ey = t;
    end
    if (sx > ex) begin
      t = sx; sx = ex; ex = t;
      t = sy; sy = ey; ey = t;
    end
    xlast = ex >> COORD_FRAC_BITS;
    // span over the limit gives one flagged beat
    if (xlast - (sx >> COORD_FRAC_BITS) > MAX_SPAN) begin
      c = '0;
      c.is_last = 1'b1;
      c.ovf     = 1'b1;
      expected_cells.insert(expected_cells.size(), c);
      n_ovf++;
      n_cells++;
      return;
    end
    dmaj = ex - sx;
    dmin = ey - sy;
    grad = longint'(1) << GRAD_FRAC;
    if (dmaj != 0) grad = (dmin * (longint'(1) << GRAD_FRAC)) / dmaj;
    xceil = ((sx + ONE_TILE - 1) >> COORD_FRAC_BITS) << COORD_FRAC_BITS;
    icpt  = sy * (longint'(1) << GRAD_FRAC) + grad * (xceil - sx);
    run.insert(run.size(), make_cell(sx >> COORD_FRAC_BITS, sy >> COORD_FRAC_BITS, steep));
    // one column at a time, an extra cell on a row crossing
    for (x = (sx >> COORD_FRAC_BITS) + 1; x <= xlast && run.size() < 63; x++) begin
      cur = row_trunc(icpt);
      run.insert(run.size(), make_cell(x, cur, steep));
      icpt += grad * ONE_TILE;
      if (row_trunc(icpt) != cur && run.size() < 63)
        run.insert(run.size(), make_cell(x, row_trunc(icpt), steep));
    end
    run[run.size()-1].is_last = 1'b1;
    foreach (run[i]) expected_cells.insert(expected_cells.size(), run[i]);
    n_cells += run.size();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] cell check: %s", $time, msg);
    mismatches++;
  endtask

  // compare one output beat with the oldest expected cell
  task automatic check_cell();
    cell_t want;
    if (expected_cells.size() == 0) begin
      report_mismatch($sformatf("unexpected beat col %0d row %0d last %0b ovf %0b",
                                out_tdata[CELL_W-1:0], out_tdata[2*CELL_W-1:CELL_W],
                                out_tlast, out_tuser));
      return;
    end
    want = expected_cells.pop_front();
    if (out_tdata[CELL_W-1:0] !== want.col)
      report_mismatch($sformatf("tile_col %0d, want %0d", out_tdata[CELL_W-1:0], want.col));
    if (out_tdata[2*CELL_W-1:CELL_W] !== want.row)
      report_mismatch($sformatf("tile_row %0d, want %0d",
                                out_tdata[2*CELL_W-1:CELL_W], want.row));
    if (out_tlast !== want.is_last)
      report_mismatch($sformatf("last %0b, want %0b", out_tlast, want.is_last));
    if (out_tuser !== want.ovf)
      report_mismatch($sformatf("span_overflow %0b, want %0b", out_tuser, want.ovf));
  endtask

  function automatic logic [IN_W-1:0] pack_seg(input int sx, input int sy,
                                               input int ex, input int ey);
    pack_seg = '0;
    pack_seg[COORD_W-1:0]           = COORD_W'(sx);
    pack_seg[2*COORD_W-1:COORD_W]   = COORD_W'(sy);
    pack_seg[3*COORD_W-1:2*COORD_W] = COORD_W'(ex);
    pack_seg[4*COORD_W-1:3*COORD_W] = COORD_W'(ey);
  endfunction

  // queue one segment beat for the driver
  function automatic void add_seg(input logic [IN_W-1:0] b);
    seg_beats.insert(seg_beats.size(), b);
  endfunction

  // end point a given distance away, mirrored if it would leave the coordinate range
  function automatic int offset_coord(input int base, input int delta);
    if (base + delta > COORD_MAX || base + delta < 0) return base - delta;
    return base + delta;
  endfunction

  // random segment, mostly short walkable ones
  function automatic logic [IN_W-1:0] random_segment();
    int kind, max_tiles, dmaj, dmin, sx, sy, ex, ey, t;
    kind = $urandom_range(0, 99);
    sx = $urandom_range(0, COORD_MAX);
    sy = $urandom_range(0, COORD_MAX);
    if (kind < 8) begin
      ex = $urandom_range(0, COORD_MAX);
      ey = $urandom_range(0, COORD_MAX);
    end else begin
      max_tiles = (kind < 70) ? $urandom_range(0, 6) : $urandom_range(0, MAX_SPAN);
      dmaj = $urandom_range(0, max_tiles * int'(ONE_TILE) + int'(ONE_TILE) - 1);
      case ($urandom_range(0, 9))
        0: dmin = 0;
        1: dmin = dmaj;
        default: dmin = $urandom_range(0, dmaj);
      endcase
      if ($urandom_range(0, 1)) begin
        t = dmaj; dmaj = dmin; dmin = t;
      end
      if ($urandom_range(0, 1)) dmaj = -dmaj;
      if ($urandom_range(0, 1)) dmin = -dmin;
      ex = offset_coord(sx, dmaj);
      ey = offset_coord(sy, dmin);
    end
    // integer end points now and then
    if ($urandom_range(0, 9) == 0) begin
      sx = sx & ~(int'(ONE_TILE) - 1);
      sy = sy & ~(int'(ONE_TILE) - 1);
      ex = ex & ~(int'(ONE_TILE) - 1);
      ey = ey & ~(int'(ONE_TILE) - 1);
    end
    return pack_seg(sx, sy, ex, ey);
  endfunction

  // tile.fraction in Q12.12, fraction given in 1/4096
  function automatic int q(input int whole, input int frac);
    return whole * int'(ONE_TILE) + frac;
  endfunction

  // input driver, fed from the pending segment queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (seg_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_tdata  <= seg_beats.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // monitor: predict on accepted segments, check accepted cells
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_cells(in_tdata);
      if (out_tvalid && out_tready) check_cell();
    end
  end

  // sender holds off until every expected cell has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (seg_beats.size() != 0 || in_tvalid || expected_cells.size() != 0);
  endtask

  // stimulus phases
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed segments, no idling
    add_seg(pack_seg(0, 0, 0, 0));
    add_seg(pack_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    add_seg(pack_seg(q(5, 0), q(3, 0), q(9, 0), q(3, 0)));
    add_seg(pack_seg(q(9, 2048), q(3, 1024), q(2, 3072), q(3, 1024)));
    add_seg(pack_seg(q(4, 2048), q(1, 0), q(4, 2048), q(20, 3072)));
    add_seg(pack_seg(0, 0, q(10, 0), q(10, 0)));
    add_seg(pack_seg(q(10, 819), q(30, 3686), q(12, 2867), q(2, 410)));
    add_seg(pack_seg(q(0, 1229), q(7, 3686), q(25, 2458), q(0, 410)));
    add_seg(pack_seg(q(0, 3686), 0, q(31, 410), q(31, 0)));
    add_seg(pack_seg(0, 0, q(32, 0), 0));
    add_seg(pack_seg(0, 0, 0, q(4095, 3686)));
    add_seg(pack_seg(q(4080, 2048), q(4090, 410), COORD_MAX, COORD_MAX));
    add_seg(pack_seg(0, 0, COORD_MAX, COORD_MAX));
    add_seg(pack_seg(24'hAAAAAA, 24'h555555, 24'hAAFFFF, 24'h550000));
    add_seg(pack_seg(24'h555555, 24'hAAAAAA, 24'h550000, 24'hAAFFFF));
    add_seg(pack_seg(q(3, 410), q(3, 410), q(3, 3686), q(3, 819)));
    // intercept dips just below zero at the far end
    add_seg(pack_seg(q(5, 1229), 0, q(0, 2867), q(0, 3686)));
    add_seg(pack_seg(q(7, 3072), q(12, 2048), q(6, 1024), q(0, 512)));
    add_seg(pack_seg(q(20, 0), q(2, 0), q(2, 0), q(20, 0)));
    add_seg(pack_seg(q(100, 4095), q(200, 1), q(131, 0), q(169, 4095)));
    wait_drained();

    // random segments over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int i = 0; i < 103; i++) add_seg(random_segment());
      wait_drained();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_cells.size() != 0)
      report_mismatch($sformatf("%0d expected cells never came", expected_cells.size()));
    $display("covered %0d segments (%0d steep, %0d over the span limit), %0d cells checked",
             n_segs, n_steep, n_ovf, n_cells);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d cells outstanding", expected_cells.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
